// ===== rtl/kis_pkg.sv =====
// Shared constants and types of the keyed insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package kis_pkg;

  // Store depth; the block holds up to this many (key, payload) pairs per list.
  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  // Fill count and scan index need one more bit: the count reaches MAX_ITEMS,
  // and the index steps below zero when the scan passes the bottom entry.
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned ENTRY_W   = KEY_W + PAY_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } kis_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch a new item and start its scan
    logic idx_clr;   // reset the index to the bottom entry for output
    logic shift;     // move the entry under the index up by one slot
    logic insert;    // write the new item into the gap
    logic emit;      // read the next entry for output
    logic clear;     // empty the store after the list went out
  } kis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // store holds MAX_ITEMS entries
    logic neg;       // scan index has passed below the bottom entry
    logic moves;     // entry under the index must move above the new item
    logic last;      // the item being inserted closes the list
    logic emit_last; // the entry being read for output is the top one
  } kis_stat_t;

endpackage

`default_nettype wire

// ===== rtl/kis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kis_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/kis_datapath.sv =====
// Datapath of the keyed insertion sorter: store, index, fill count, compare.
`timescale 1ns / 1ps
`default_nettype none

module kis_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire kis_pkg::kis_cmd_t                  cmd_i,
  output kis_pkg::kis_stat_t                      stat_o,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_descending_i,
  input  wire logic signed [kis_pkg::KEY_W-1:0]   sort_key_i,
  input  wire logic        [kis_pkg::PAY_W-1:0]   payload_word_i,
  input  wire logic                               last_item_i,
  output logic                                    result_valid_o,
  output logic signed      [kis_pkg::KEY_W-1:0]   sorted_key_o,
  output logic             [kis_pkg::PAY_W-1:0]   sorted_payload_o,
  output logic                                    end_of_list_o,
  output logic                                    overflowed_o
);

  import kis_pkg::*;

  logic [CNT_W-1:0]        fill_q, fill_d, idx_q, idx_d;
  logic [CNT_W-1:0]        fill_m1, idx_m1, idx_p1;
  logic signed [KEY_W-1:0] key_q;
  logic [PAY_W-1:0]        pay_q;
  logic                    last_q, dropped_q, dropped_d, desc_q;
  logic                    out_vld_q, out_eol_q;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic signed [KEY_W-1:0] rd_key;

  assign fill_m1 = fill_q - 1'b1;
  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign rd_key  = ram_rdata[ENTRY_W-1:PAY_W];

  assign stat_o.full      = (fill_q == CNT_W'(MAX_ITEMS));
  assign stat_o.neg       = idx_q[CNT_W-1];
  assign stat_o.moves     = desc_q ? (rd_key < key_q) : (rd_key > key_q);
  assign stat_o.last      = last_q;
  assign stat_o.emit_last = (idx_q == fill_m1);

  // One entry moves per cycle: the write of slot idx+1 and the read of
  // slot idx-1 share the same edge.
  assign ram_we    = cmd_i.shift | cmd_i.insert;
  assign ram_waddr = idx_p1[ADDR_W-1:0];
  assign ram_wdata = cmd_i.shift ? ram_rdata : {key_q, pay_q};

  always_comb begin
    if (cmd_i.capture) begin
      ram_raddr = fill_m1[ADDR_W-1:0];
    end else if (cmd_i.shift) begin
      ram_raddr = idx_m1[ADDR_W-1:0];
    end else begin
      ram_raddr = idx_q[ADDR_W-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.capture) begin
      idx_d = fill_m1;
    end else if (cmd_i.shift) begin
      idx_d = idx_m1;
    end else if (cmd_i.emit) begin
      idx_d = idx_p1;
    end
  end

  always_comb begin
    fill_d    = fill_q;
    dropped_d = dropped_q;
    if (cmd_i.insert) begin
      fill_d = fill_q + 1'b1;
    end
    if (cmd_i.capture && stat_o.full) begin
      dropped_d = 1'b1;
    end
    if (cmd_i.clear) begin
      fill_d    = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      idx_q     <= '0;
      dropped_q <= 1'b0;
      desc_q    <= 1'b0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
      out_eol_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      dropped_q <= dropped_d;
      out_vld_q <= cmd_i.emit;
      out_eol_q <= cmd_i.emit & stat_o.emit_last;
      if (cfg_we_i) begin
        desc_q <= cfg_descending_i;
      end
      if (cmd_i.capture) begin
        last_q <= last_item_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= sort_key_i;
      pay_q <= payload_word_i;
    end
  end

  kis_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o   = out_vld_q;
  assign sorted_key_o     = ram_rdata[ENTRY_W-1:PAY_W];
  assign sorted_payload_o = ram_rdata[PAY_W-1:0];
  assign end_of_list_o    = out_eol_q;
  assign overflowed_o     = dropped_q;

endmodule

`default_nettype wire

// ===== rtl/kis_ctrl.sv =====
// Controller state machine of the keyed insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

module kis_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               last_item_i,
  input  wire kis_pkg::kis_stat_t stat_i,
  output kis_pkg::kis_cmd_t       cmd_o,
  output logic                    busy_o
);

  import kis_pkg::*;

  kis_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.full) begin
            // The item is dropped; a closing item still sends the list out.
            if (last_item_i) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_EMIT;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stat_i.neg && stat_i.moves) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          if (stat_i.last) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/keyed_insertion_sorter.sv =====
// Top level of the keyed insertion sorter: controller, datapath and store.
`timescale 1ns / 1ps
`default_nettype none

// Stable insertion sorter of (key, payload) pairs, up to MAX_ITEMS per list.
// Input: an item transfer happens at a rising edge with start_i high and
// busy_o low. It carries a signed key, a payload word and a last flag.
// Each item is inserted into a sorted store (ascending, or descending when
// the configuration register is set); equal keys keep arrival order.
// Insertion walks the single-port-write store one entry per cycle from the
// top down, and after its transfer an item keeps busy_o high while entries
// move and until it is written; the next item can follow in the first cycle
// with busy_o low. A dropped item that is not flagged last leaves busy_o
// low. The one store write port sets this rate.
// On the item flagged last, the whole list goes out one result per cycle:
// the store is read in the emit state that follows the insert (or the
// transfer of a dropped last item), each result is registered out of it,
// the results follow with no gap, and busy_o is low again in the cycle right
// after the last result.
// Each result is on the ports for exactly one cycle with result_valid_o
// high; the receiver cannot stall, so nothing is held back.
// If the store is full, further items are dropped and every result of that
// list shows overflowed_o.
// Configuration: one register (descending), written through the cfg channel
// when cfg_valid_i and cfg_ready_o are both high; ready is given while idle.
// Reset clears the fill count, the drop flag, the register and the state
// machine; store contents are not cleared and need no clearing pass.

module keyed_insertion_sorter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [kis_pkg::KEY_W-1:0] sort_key_i,
  input  wire logic        [kis_pkg::PAY_W-1:0] payload_word_i,
  input  wire logic                             last_item_i,
  output logic                                  result_valid_o,
  output logic signed      [kis_pkg::KEY_W-1:0] sorted_key_o,
  output logic             [kis_pkg::PAY_W-1:0] sorted_payload_o,
  output logic                                  end_of_list_o,
  output logic                                  overflowed_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_descending_i
);

  import kis_pkg::*;

  kis_cmd_t  cmd;
  kis_stat_t stat;
  logic      cfg_we;

  // Configuration only lands while busy_o is low: no item is being inserted and no list is being sent out.
  assign cfg_ready_o = ~busy_o;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  kis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_item_i (last_item_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  kis_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we),
    .cfg_descending_i (cfg_descending_i),
    .sort_key_i       (sort_key_i),
    .payload_word_i   (payload_word_i),
    .last_item_i      (last_item_i),
    .result_valid_o   (result_valid_o),
    .sorted_key_o     (sorted_key_o),
    .sorted_payload_o (sorted_payload_o),
    .end_of_list_o    (end_of_list_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

`default_nettype wire

// ===== rtl/kis_checker.sv =====
// Port-level assertions for the keyed insertion sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kis_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic last_item_i,
  input wire logic result_valid_o,
  input wire logic end_of_list_o
);

  // Results only appear while a list is being sent out.
  a_result_when_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> busy_o
  ) else $error("result transfer while idle");

  // The end flag only marks a real result.
  a_eol_with_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni) end_of_list_o |-> result_valid_o
  ) else $error("end_of_list without result");

  // Nothing follows the final result of a list.
  a_eol_closes_list: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (result_valid_o && end_of_list_o) |=> (!result_valid_o && !busy_o)
  ) else $error("output continued after end of list");

  // An item that does not close the list never starts output.
  a_no_emit_mid_list: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o && !last_item_i) |=> !result_valid_o
  ) else $error("output started without a last item");

endmodule

bind keyed_insertion_sorter kis_checker u_kis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_item_i    (last_item_i),
  .result_valid_o (result_valid_o),
  .end_of_list_o  (end_of_list_o)
);

`default_nettype wire
